// ===== src/hbs_pkg.sv =====
// types and constants for the heightmap bilinear sampler
// shared by hbs_store, hbs_blend and the top level under src; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package hbs_pkg;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_ORIGIN_X   = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Z   = 2'd1;
  localparam logic [1:0] CFG_GRID_SCALE = 2'd2;

  // grid_scale after reset: one cell per world unit, Q8.16
  localparam logic [23:0] SCALE_RESET = 24'd65536;

  typedef struct packed {
    logic               command;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_z;
    logic        [6:0]  row;
    logic        [6:0]  column;
    logic signed [15:0] sample;
  } item_t;

  typedef struct packed {
    logic signed [15:0] height;
    logic               outside;
  } result_t;

  // four corners of one cell, rows follow z and columns follow x
  typedef struct packed {
    logic signed [15:0] h00;
    logic signed [15:0] h01;
    logic signed [15:0] h10;
    logic signed [15:0] h11;
  } corners_t;

endpackage

`default_nettype wire

// ===== src/hbs_ram.sv =====
// generic simple dual port ram, one write and one registered read port
// stand-alone; no package needed
`timescale 1ns / 1ps
`default_nettype none

module hbs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/hbs_locate.sv =====
// one axis of the query: subtract origin, scale to grid units, split into cell and fraction
// two register stages; no package needed
`timescale 1ns / 1ps
`default_nettype none

module hbs_locate #(
  parameter int GRID_POINTS = 128
) (
  input  wire logic                             clk,
  input  wire logic signed [23:0]               coord,
  input  wire logic signed [23:0]               origin,
  input  wire logic        [23:0]               scale,
  output logic             [$clog2(GRID_POINTS)-1:0] cell_idx,
  output logic             [15:0]               frac,
  output logic                                  outside
);

  localparam int IW = $clog2(GRID_POINTS);

  logic signed [24:0] local_pos;
  logic signed [49:0] grid_pos;

  always_ff @(posedge clk) begin
    local_pos <= $signed({coord[23], coord}) - $signed({origin[23], origin});
    grid_pos  <= local_pos * $signed({1'b0, scale});
  end

  // negative means floor gave a negative cell
  always_comb begin
    outside  = grid_pos[49] || (grid_pos[47:24] >= 24'(GRID_POINTS - 1));
    cell_idx = grid_pos[24 +: IW];
    frac     = grid_pos[23:8];
  end

endmodule

`default_nettype wire

// ===== src/hbs_store.sv =====
// height store split into four banks by row and column parity
// reads all four corners of a cell at once, one from each bank; uses hbs_pkg and hbs_ram
`timescale 1ns / 1ps
`default_nettype none

module hbs_store #(
  parameter int GRID_POINTS = 128
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [6:0]                            wr_row,
  input  wire logic [6:0]                            wr_column,
  input  wire logic signed [15:0]                    wr_sample,
  input  wire logic [$clog2(GRID_POINTS)-1:0]        cell_x,
  input  wire logic [$clog2(GRID_POINTS)-1:0]        cell_z,
  output hbs_pkg::corners_t                          corners
);

  import hbs_pkg::*;

  localparam int IW    = $clog2(GRID_POINTS);
  localparam int HALF  = (GRID_POINTS + 1) / 2;
  localparam int DEPTH = HALF * HALF;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

  logic          wr_in_grid;
  logic [AW-1:0] waddr;
  logic [15:0]   rd_data [4];
  logic          par_x;
  logic          par_z;

  always_comb begin
    wr_in_grid = (32'(wr_row) < 32'(GRID_POINTS)) && (32'(wr_column) < 32'(GRID_POINTS));
    waddr      = AW'(int'(wr_row[6:1]) * HALF + int'(wr_column[6:1]));
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BANK_ROW = 1'((b >> 1) & 1);
    localparam logic BANK_COL = 1'(b & 1);

    logic [IW:0]   row_sel;
    logic [IW:0]   col_sel;
    logic [AW-1:0] raddr;
    logic          we;

    // the corner row (column) of this parity is the cell's own or the next one
    always_comb begin
      row_sel = (IW + 1)'(cell_z) + (IW + 1)'(BANK_ROW ^ cell_z[0]);
      col_sel = (IW + 1)'(cell_x) + (IW + 1)'(BANK_COL ^ cell_x[0]);
      raddr   = AW'(int'(row_sel[IW:1]) * HALF + int'(col_sel[IW:1]));
      we      = wr_en && wr_in_grid && (wr_row[0] == BANK_ROW) && (wr_column[0] == BANK_COL);
    end

    hbs_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wr_sample),
      .raddr (raddr),
      .rdata (rd_data[b])
    );
  end

  always_ff @(posedge clk) begin
    par_x <= cell_x[0];
    par_z <= cell_z[0];
  end

  always_comb begin
    corners.h00 = rd_data[{par_z, par_x}];
    corners.h01 = rd_data[{par_z, ~par_x}];
    corners.h10 = rd_data[{~par_z, par_x}];
    corners.h11 = rd_data[{~par_z, ~par_x}];
  end

endmodule

`default_nettype wire

// ===== src/hbs_blend.sv =====
// bilinear blend of four corners, rounding and saturation to Q7.8
// three register stages ending in the result register; uses hbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module hbs_blend (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              valid,
  input  wire logic              outside,
  input  wire logic [15:0]       frac_x,
  input  wire logic [15:0]       frac_z,
  input  wire hbs_pkg::corners_t corners,
  output logic                   done,
  output hbs_pkg::result_t       result
);

  import hbs_pkg::*;

  logic               v_ab;
  logic               out_ab;
  logic        [15:0] fz_ab;
  logic signed [33:0] row_a;
  logic signed [33:0] row_b;
  logic               v_acc;
  logic               out_acc;
  logic signed [51:0] acc;

  logic signed [16:0] diff_a;
  logic signed [16:0] diff_b;
  logic signed [33:0] row_a_next;
  logic signed [33:0] row_b_next;
  logic signed [34:0] diff_ab;
  logic signed [51:0] acc_next;
  logic signed [51:0] rounded;
  logic signed [19:0] h_full;
  logic signed [15:0] h_sat;

  // a = h00 + (h01 - h00) * fx, in Q.24
  always_comb begin
    diff_a     = 17'(corners.h01) - 17'(corners.h00);
    diff_b     = 17'(corners.h11) - 17'(corners.h10);
    row_a_next = $signed({{2{corners.h00[15]}}, corners.h00, 16'd0})
               + diff_a * $signed({1'b0, frac_x});
    row_b_next = $signed({{2{corners.h10[15]}}, corners.h10, 16'd0})
               + diff_b * $signed({1'b0, frac_x});
  end

  always_comb begin
    diff_ab  = 35'(row_b) - 35'(row_a);
    acc_next = $signed({{2{row_a[33]}}, row_a, 16'd0}) + diff_ab * $signed({1'b0, fz_ab});
  end

  // Q.40 to Q.8, halves toward plus infinity
  always_comb begin
    rounded = acc + 52'sd2147483648;
    h_full  = rounded[51:32];
    if (h_full > 20'sd32767) begin
      h_sat = 16'sd32767;
    end else if (h_full < -20'sd32768) begin
      h_sat = -16'sd32768;
    end else begin
      h_sat = h_full[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_ab  <= 1'b0;
      v_acc <= 1'b0;
      done  <= 1'b0;
    end else begin
      v_ab  <= valid;
      v_acc <= v_ab;
      done  <= v_acc;
    end
    out_ab         <= outside;
    fz_ab          <= frac_z;
    row_a          <= row_a_next;
    row_b          <= row_b_next;
    out_acc        <= out_ab;
    acc            <= acc_next;
    result.outside <= out_acc;
    result.height  <= out_acc ? 16'sd0 : h_sat;
  end

endmodule

`default_nettype wire

// ===== src/heightmap_bilinear_sampler.sv =====
// top level of the heightmap bilinear sampler: command port, config registers, pipeline
// uses hbs_pkg, hbs_locate, hbs_store, hbs_blend (and hbs_ram through hbs_store)
`timescale 1ns / 1ps
`default_nettype none

// a query's result passes the stage registers and the blend registers, then strobes on done
// throughput: one transaction per cycle, writes and queries mixed freely; busy stays low
// the four corners come from four parity banks in one read, so the pipeline never stalls
// writes commit at the same stage where queries read, so order is kept without forwarding
// reset clears the pipeline valids and the config registers; the sample store is not cleared
// the receiver cannot stall: each result is on the ports for one cycle only

module heightmap_bilinear_sampler #(
  parameter int GRID_POINTS = 128
) (
  input  wire logic            clk,
  input  wire logic            rst,
  // command transaction
  input  wire logic            start,
  output logic                 busy,
  input  wire hbs_pkg::item_t  item,
  // result
  output logic                 done,
  output hbs_pkg::result_t     result,
  // config write channel
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [1:0]      cfg_index,
  input  wire logic [23:0]     cfg_data
);

  import hbs_pkg::*;

  localparam int IW = $clog2(GRID_POINTS);

  // config registers
  logic signed [23:0] origin_x;
  logic signed [23:0] origin_z;
  logic        [23:0] grid_scale;

  // stage 1: operands latched with the transaction, axes subtracting origin
  logic               v1;
  logic               cmd1;
  logic        [6:0]  row1;
  logic        [6:0]  column1;
  logic signed [15:0] sample1;

  // stage 2: grid position ready, store accessed
  logic               v2;
  logic               cmd2;
  logic        [6:0]  row2;
  logic        [6:0]  column2;
  logic signed [15:0] sample2;

  // stage 3: corners back from the banks
  logic               v3;
  logic               out3;
  logic        [15:0] fx3;
  logic        [15:0] fz3;

  logic [IW-1:0]      cell_x;
  logic [IW-1:0]      cell_z;
  logic [15:0]        frac_x;
  logic [15:0]        frac_z;
  logic               out_x;
  logic               out_z;
  logic               accept;
  corners_t           corners;

  // every transaction flows straight through; nothing ever holds the port off
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      origin_z   <= '0;
      grid_scale <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORIGIN_X:   origin_x   <= cfg_data;
        CFG_ORIGIN_Z:   origin_z   <= cfg_data;
        CFG_GRID_SCALE: grid_scale <= cfg_data;
        default: begin
          // unknown index, nothing to write
        end
      endcase
    end
  end

  // control pipeline; payload registers carry no reset
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2 && (cmd2 == CMD_QUERY);
    end
    cmd1    <= item.command;
    row1    <= item.row;
    column1 <= item.column;
    sample1 <= item.sample;
    cmd2    <= cmd1;
    row2    <= row1;
    column2 <= column1;
    sample2 <= sample1;
    out3    <= out_x || out_z;
    fx3     <= frac_x;
    fz3     <= frac_z;
  end

  // rows follow z, columns follow x
  hbs_locate #(
    .GRID_POINTS (GRID_POINTS)
  ) u_locate_x (
    .clk      (clk),
    .coord    (item.coord_x),
    .origin   (origin_x),
    .scale    (grid_scale),
    .cell_idx (cell_x),
    .frac     (frac_x),
    .outside  (out_x)
  );

  hbs_locate #(
    .GRID_POINTS (GRID_POINTS)
  ) u_locate_z (
    .clk      (clk),
    .coord    (item.coord_z),
    .origin   (origin_z),
    .scale    (grid_scale),
    .cell_idx (cell_z),
    .frac     (frac_z),
    .outside  (out_z)
  );

  // a query outside the grid still reads some cell; its data is dropped in the blend
  hbs_store #(
    .GRID_POINTS (GRID_POINTS)
  ) u_store (
    .clk       (clk),
    .wr_en     (v2 && (cmd2 == CMD_WRITE)),
    .wr_row    (row2),
    .wr_column (column2),
    .wr_sample (sample2),
    .cell_x    (cell_x),
    .cell_z    (cell_z),
    .corners   (corners)
  );

  hbs_blend u_blend (
    .clk     (clk),
    .rst     (rst),
    .valid   (v3),
    .outside (out3),
    .frac_x  (fx3),
    .frac_z  (fz3),
    .corners (corners),
    .done    (done),
    .result  (result)
  );

  // every query transaction gives its result, seen on done
  assert property (@(posedge clk) disable iff (rst)
    (accept && (item.command == CMD_QUERY)) |-> ##6 done)
    else $error("query transaction gave no result");

  // no result without an earlier query, so writes give none
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept && (item.command == CMD_QUERY), 6))
    else $error("result without a query");

  // an outside query always reports height zero
  assert property (@(posedge clk) disable iff (rst)
    (done && result.outside) |-> (result.height == 16'sd0))
    else $error("outside result with non-zero height");

endmodule

`default_nettype wire

// ===== tb/heightmap_bilinear_sampler_test.sv =====
// self-checking testbench for heightmap_bilinear_sampler: random and directed commands
// against a cycle-free predictor of the sample grid and its bilinear blend
// depends on hbs_pkg and the sampler rtl under src
`timescale 1ns / 1ps

module heightmap_bilinear_sampler_test;
  import hbs_pkg::*;

  localparam int GRID_POINTS = 128;
  // index past the three registers, must be ignored by the block
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  // wait after the last result, long enough for trailing writes to commit too
  localparam int SETTLE_CYCLES = 8;
  // worst case: every command waiting out the longest gap
  localparam longint CYCLE_LIMIT = 400_000;
  localparam int RANDOM_PER_PHASE = 64;

  typedef struct packed {
    logic [1:0]  index;
    logic [23:0] value;
  } cfg_write_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  item_t       item_bus = '0;
  logic        done;
  result_t     result_bus;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  heightmap_bilinear_sampler #(
    .GRID_POINTS(GRID_POINTS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item_bus),
    .done(done),
    .result(result_bus),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: its own copy of the grid and of the three registers
  // ---------------------------------------------------------------------------
  logic signed [15:0] height_grid [GRID_POINTS * GRID_POINTS];
  logic signed [23:0] origin_x_cfg = '0;
  logic signed [23:0] origin_z_cfg = '0;
  logic        [23:0] scale_cfg = SCALE_RESET;
  // samples already queued for writing, so a query never reads an unwritten one
  bit                 written_map [GRID_POINTS * GRID_POINTS];

  item_t      command_queue [$];   // commands waiting for the driver
  result_t    height_expect [$];   // predicted results, oldest first
  cfg_write_t setting_queue [$];   // register writes for the next idle window

  int     issued_count = 0;
  int     accepted_count = 0;
  int     error_count = 0;
  int     gap_left = 0;
  int     calm_left = 0;
  longint cycle_count = 0;

  // one axis: world coordinate to cell index and Q0.16 fraction, 0 when outside
  function automatic bit locate_axis(input logic signed [23:0] coord,
                                     input logic signed [23:0] origin,
                                     output int cell_idx, output longint frac);
    longint offset;
    longint g;
    offset = longint'(coord) - longint'(origin);
    g = offset * longint'(scale_cfg);
    cell_idx = 0;
    frac = 0;
    // floor of a negative position lands below cell zero
    if (g < 0) return 1'b0;
    // at or past the last full cell there are no four corners to blend
    if ((g >>> 24) >= GRID_POINTS - 1) return 1'b0;
    cell_idx = int'(g >>> 24);
    frac = (g >>> 8) & 64'hFFFF;
    return 1'b1;
  endfunction

  function automatic result_t interpolate_height(input item_t query);
    result_t r;
    int      cx, cz, base;
    longint  fx, fz, h00, h01, h10, h11, row_a, row_b, acc, rounded;
    bit      in_x, in_z;
    in_x = locate_axis(query.coord_x, origin_x_cfg, cx, fx);
    in_z = locate_axis(query.coord_z, origin_z_cfg, cz, fz);
    r.height = '0;
    r.outside = 1'b1;
    if (!(in_x && in_z)) return r;
    // rows follow z, columns follow x
    base = cz * GRID_POINTS + cx;
    h00 = height_grid[base];
    h01 = height_grid[base + 1];
    h10 = height_grid[base + GRID_POINTS];
    h11 = height_grid[base + GRID_POINTS + 1];
    row_a = h00 * (65536 - fx) + h01 * fx;
    row_b = h10 * (65536 - fx) + h11 * fx;
    acc = row_a * (65536 - fz) + row_b * fz;
    // Q.40 down to Q.8, halves toward plus infinity, then saturate
    rounded = (acc + (64'sd1 <<< 31)) >>> 32;
    if (rounded > 32767) rounded = 32767;
    else if (rounded < -32768) rounded = -32768;
    r.height = rounded[15:0];
    r.outside = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] random_sample();
    case ($urandom_range(0, 19))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // unused fields carry random bits so the block is seen to ignore them
  task automatic push_write(input int r, input int c, input logic [15:0] value);
    item_t it;
    it.command = CMD_WRITE;
    it.coord_x = 24'($urandom);
    it.coord_z = 24'($urandom);
    it.row = r[6:0];
    it.column = c[6:0];
    it.sample = value;
    command_queue.push_back(it);
    written_map[r * GRID_POINTS + c] = 1'b1;
    issued_count++;
  endtask

  // corners of the hit cell that were never written get a value just before the query
  task automatic push_query(input logic [23:0] x, input logic [23:0] z);
    item_t  it;
    int     cx, cz;
    longint fx, fz;
    if (locate_axis(x, origin_x_cfg, cx, fx) && locate_axis(z, origin_z_cfg, cz, fz)) begin
      for (int dz = 0; dz < 2; dz++)
        for (int dx = 0; dx < 2; dx++)
          if (!written_map[(cz + dz) * GRID_POINTS + cx + dx])
            push_write(cz + dz, cx + dx, random_sample());
    end
    it.command = CMD_QUERY;
    it.coord_x = x;
    it.coord_z = z;
    it.row = 7'($urandom);
    it.column = 7'($urandom);
    it.sample = 16'($urandom);
    command_queue.push_back(it);
    issued_count++;
  endtask

  // pick a world coordinate, mostly aimed at a grid position under the current scale
  function automatic logic [23:0] aim_axis(input logic signed [23:0] origin);
    longint target, offset;
    int     pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return 24'($urandom);
    if (pick < 80)
      target = (longint'($urandom_range(0, GRID_POINTS - 2)) <<< 24)
               + longint'($urandom_range(0, 24'hFFFFFF));
    else if (pick < 88)
      // just past the last full cell
      target = (longint'(GRID_POINTS - 1) <<< 24) + longint'($urandom_range(0, 24'hFFFF));
    else if (pick < 94)
      // top end of the last full cell
      target = (longint'(GRID_POINTS - 2) <<< 24)
               + longint'($urandom_range(24'hFF0000, 24'hFFFFFF));
    else
      // slightly below the tile corner
      target = -longint'($urandom_range(1, 24'hFFFFFF));
    if (scale_cfg == 0) begin
      offset = longint'($urandom_range(0, 255));
      if (target < 0) offset = -offset - 1;
    end else begin
      offset = target / longint'(scale_cfg);
      if (target < 0) offset = offset - 1;
    end
    return 24'(longint'(origin) + offset);
  endfunction

  task automatic push_random_commands(input int count);
    repeat (count) begin
      if ($urandom_range(0, 99) < 35)
        push_write($urandom_range(0, GRID_POINTS - 1), $urandom_range(0, GRID_POINTS - 1),
                   random_sample());
      else
        push_query(aim_axis(origin_x_cfg), aim_axis(origin_z_cfg));
    end
  endtask

  // mostly back to back or short gaps, the odd long one, and calm stretches with none
  function automatic int pick_gap();
    int pick;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      calm_left = $urandom_range(30, 100);
      return 0;
    end
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 2);
    if (pick < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_setting(input logic [1:0] index, input logic [23:0] value);
    cfg_write_t w;
    w.index = index;
    w.value = value;
    setting_queue.push_back(w);
  endtask

  // register writes back to back; valid is only lowered after the last one
  task automatic apply_settings();
    cfg_write_t w;
    while (setting_queue.size() != 0) begin
      w = setting_queue.pop_front();
      cfg_index <= w.index;
      cfg_data <= w.value;
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      case (w.index)
        CFG_ORIGIN_X:   origin_x_cfg = w.value;
        CFG_ORIGIN_Z:   origin_z_cfg = w.value;
        CFG_GRID_SCALE: scale_cfg = w.value;
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // every command taken, every result seen, then room for a trailing write to land
  task automatic wait_idle();
    while (accepted_count != issued_count || height_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // driver: one command transaction per handshake, prediction made on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (item_bus.command == CMD_QUERY)
          height_expect.push_back(interpolate_height(item_bus));
        else
          height_grid[{item_bus.row, item_bus.column}] = item_bus.sample;
        accepted_count++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (command_queue.size() != 0) begin
          item_bus <= command_queue.pop_front();
          start <= 1'b1;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: each strobed result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst && done) begin
      if (height_expect.size() == 0) begin
        $error("result with no query pending: height %0d outside %0b",
               result_bus.height, result_bus.outside);
        error_count++;
      end else begin
        want = height_expect.pop_front();
        if (result_bus.height !== want.height) begin
          $error("height: expected %0d, got %0d", want.height, result_bus.height);
          error_count++;
        end
        if (result_bus.outside !== want.outside) begin
          $error("outside: expected %0b, got %0b", want.outside, result_bus.outside);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // phases: directed cases, then random traffic under several settings
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part under the reset settings: one cell per world unit, origin zero
    // corners at both extremes of the sample range
    push_write(0, 0, 16'h7FFF);
    push_write(0, 1, 16'h7FFF);
    push_write(1, 0, 16'h8000);
    push_write(1, 1, 16'h8000);
    push_query(24'h000000, 24'h000000);
    push_query(24'h000080, 24'h000000);
    push_query(24'h000000, 24'h000080);
    // a half exactly between 0 and 1 rounds up, between 0 and -1 rounds up to zero
    push_write(5, 5, 16'h0000);
    push_write(5, 6, 16'h0001);
    push_query(24'h000580, 24'h000500);
    push_write(5, 6, 16'hFFFF);
    push_query(24'h000580, 24'h000500);
    // last grid point written straight before the query of the last full cell
    push_write(GRID_POINTS - 2, GRID_POINTS - 2, random_sample());
    push_write(GRID_POINTS - 2, GRID_POINTS - 1, random_sample());
    push_write(GRID_POINTS - 1, GRID_POINTS - 2, random_sample());
    push_write(GRID_POINTS - 1, GRID_POINTS - 1, 16'h1234);
    push_query(24'h007EFF, 24'h007EFF);
    // first cell past the last full cell, on each axis
    push_query(24'h007F00, 24'h000100);
    push_query(24'h000100, 24'h007F00);
    // just below the origin: floor, not truncation
    push_query(24'hFFFFFF, 24'h000100);
    push_query(24'h000100, 24'hFFFFFF);
    // coordinate extremes
    push_query(24'h7FFFFF, 24'h7FFFFF);
    push_query(24'h800000, 24'h800000);
    push_random_commands(RANDOM_PER_PHASE);
    wait_idle();

    // extreme origins with the largest scale
    queue_setting(CFG_ORIGIN_X, 24'h800000);
    queue_setting(CFG_ORIGIN_Z, 24'h7FFFFF);
    queue_setting(CFG_GRID_SCALE, 24'hFFFFFF);
    apply_settings();
    push_random_commands(RANDOM_PER_PHASE);
    wait_idle();

    // zero scale pins everything to cell zero; an unused index must change nothing
    queue_setting(CFG_GRID_SCALE, 24'h000000);
    queue_setting(CFG_ORIGIN_X, 24'($urandom));
    queue_setting(CFG_UNUSED, 24'($urandom));
    queue_setting(CFG_ORIGIN_Z, 24'($urandom));
    apply_settings();
    push_random_commands(RANDOM_PER_PHASE);
    wait_idle();

    // smallest nonzero scale
    queue_setting(CFG_ORIGIN_X, 24'h000000);
    queue_setting(CFG_ORIGIN_Z, 24'h000000);
    queue_setting(CFG_GRID_SCALE, 24'h000001);
    apply_settings();
    push_random_commands(RANDOM_PER_PHASE);
    wait_idle();

    // random tile placement at a moderate scale
    queue_setting(CFG_ORIGIN_X, 24'($signed($urandom_range(0, 24'hFFFF)) - 32768));
    queue_setting(CFG_ORIGIN_Z, 24'($signed($urandom_range(0, 24'hFFFF)) - 32768));
    queue_setting(CFG_GRID_SCALE, 24'($urandom_range(24'h004000, 24'h040000)));
    apply_settings();
    push_random_commands(RANDOM_PER_PHASE);
    wait_idle();

    // half a cell per world unit, negative origins
    queue_setting(CFG_GRID_SCALE, 24'h008000);
    queue_setting(CFG_ORIGIN_X, 24'hFFF000);
    queue_setting(CFG_ORIGIN_Z, 24'hFFFF00);
    apply_settings();
    push_random_commands(RANDOM_PER_PHASE);
    wait_idle();

    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
